// File: rtl/core/svm_pkg.sv
package svm_pkg;

    typedef enum logic [4:0] {
        OP_PUSHI = 5'd0,  OP_PUSHR = 5'd1,  OP_POP   = 5'd2,  OP_ADD   = 5'd3,
        OP_SUB   = 5'd4,  OP_MUL   = 5'd5,  OP_DIV   = 5'd6,  OP_MOD   = 5'd7,
        OP_JE    = 5'd8,  OP_JNE   = 5'd9,  OP_JMP   = 5'd10, OP_LE    = 5'd11,
        OP_LT    = 5'd12, OP_GE    = 5'd13, OP_GT    = 5'd14, OP_EQ    = 5'd15,
        OP_NE    = 5'd16, OP_AND   = 5'd17, OP_OR    = 5'd18, OP_STORE = 5'd19,
        OP_LOAD  = 5'd20, OP_CALL  = 5'd21, OP_RET   = 5'd22, OP_MOVE  = 5'd23,
        OP_MOVEI = 5'd24, OP_INT   = 5'd25, OP_EXIT  = 5'd26
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_REG   = 3'd1,
        ST_DIV_ZERO  = 3'd2,
        ST_PC_RANGE  = 3'd3,
        ST_SERVICE   = 3'd4,
        ST_HALTED    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEM,
        S_DIV,
        S_DONE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the instruction and read the operands
        logic mem_rd;    // issue memory read for pop, load, ret
        logic div_start; // start the divider
        logic commit;    // write back state and load the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_mem;  // instruction reads memory
        logic need_div;  // div or mod, r3 nonzero, in range, not halted
        logic div_done;
    } dp_stat_t;

    localparam int DATA_W = 32;

endpackage

// File: rtl/core/stack_vm_instruction_execute.sv
// channel   | dir | fields (low bit first)                         | transfer when
// s_axis    | in  | op[4:0] first_operand[36:5] second_operand[68:37] | tvalid & tready
// m_axis    | out | next_pc[15:0] accumulator[47:16] halted[48] status[51:49] | tvalid & tready
// cfg       | in  | program_length[16:0]                           | cfg_we
//
// an item goes through capture operands, memory read, commit and present in turn;
// divide and modulo with a nonzero divisor, pc in range and no halt also pass the
// bit-serial divider before commit; one item at a time: the next transfer is taken
// once the result is accepted; m_axis_tready low simply holds the result; reset clears
// pc, halt and every register but the stack register, which it sets to MEM_DEPTH;
// memory contents are undefined after reset until written
module stack_vm_instruction_execute #(
    parameter int REG_COUNT = 8,
    parameter int MEM_DEPTH = 1024,
    parameter int STACK_REG = 0,
    parameter int PC_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // op, first_operand, second_operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // next_pc, accumulator, halted, status
    input  logic        cfg_we,
    input  logic [16:0] cfg_data        // program_length
);
    import svm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    svm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    // register file, memory, divider and result register
    svm_dp #(
        .REG_COUNT(REG_COUNT), .MEM_DEPTH(MEM_DEPTH),
        .STACK_REG(STACK_REG), .PC_BITS(PC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_data(s_axis_tdata[68:0]),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .out_data(m_axis_tdata)
    );
endmodule

// File: rtl/core/svm_ram.sv
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/svm_div.sv
// radix-2 restoring divide on magnitudes, one quotient bit per cycle
module svm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    import svm_pkg::*;

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            else
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// File: rtl/core/svm_ctrl.sv
module svm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  svm_pkg::dp_stat_t stat,
    output svm_pkg::dp_cmd_t  cmd
);
    import svm_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MEM;
            S_MEM:
            begin
                if (stat.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV: if (stat.div_done) state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_MEM:
            begin
                cmd.mem_rd    = stat.need_mem;
                cmd.div_start = stat.need_div;
            end
            S_DIV: ;
            S_DONE: cmd.commit = 1'b1;
            S_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and result together");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit without result");
    a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV)) else $error("divider lost");
endmodule

// File: rtl/core/svm_dp.sv
module svm_dp #(
    parameter int REG_COUNT = 8,
    parameter int MEM_DEPTH = 1024,
    parameter int STACK_REG = 0,
    parameter int PC_BITS   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  svm_pkg::dp_cmd_t  cmd,
    output svm_pkg::dp_stat_t stat,
    input  logic [68:0]       in_data,
    input  logic              cfg_we,
    input  logic [16:0]       cfg_data,
    output logic [55:0]       out_data
);
    import svm_pkg::*;

    localparam int RI = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SP = STACK_REG % REG_COUNT;

    logic [31:0] rf_reg [REG_COUNT];
    logic [PC_BITS-1:0] pc_reg;
    logic halt_reg;
    logic [16:0] plen_reg;

    logic [4:0]  op_reg;
    logic [31:0] a1_reg, a2_reg;
    logic [31:0] v1_reg, v2_reg;  // registers named by the operands
    logic        ok1_reg, ok2_reg;
    logic [31:0] mul_reg;
    logic [55:0] res_reg;

    logic [31:0] r2, r3, sp;
    logic [AW-1:0] raddr, waddr;
    logic [31:0] rdata, wdata;
    logic          we;

    logic [31:0] div_a, div_b, quo, rem;
    logic        div_done;

    assign r2 = rf_reg[2];
    assign r3 = rf_reg[3];
    assign sp = rf_reg[SP];

    logic [31:0] in_a1, in_a2;
    assign in_a1 = in_data[36:5];
    assign in_a2 = in_data[68:37];

    function automatic logic idx_ok(input logic [31:0] v);
        return v < 32'(REG_COUNT);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data[4:0];
            a1_reg  <= in_a1;
            a2_reg  <= in_a2;
            ok1_reg <= idx_ok(in_a1);
            ok2_reg <= idx_ok(in_a2);
            v1_reg  <= rf_reg[in_a1[RI-1:0]];
            v2_reg  <= rf_reg[in_a2[RI-1:0]];
            mul_reg <= r2 * r3;
        end
    end

    // stage one: memory read address
    always_comb
    begin
        case (op_reg)
            OP_LOAD: raddr = v2_reg[AW-1:0];
            default: raddr = sp[AW-1:0];
        endcase
    end

    logic live;
    assign live = !halt_reg && ({{(17 - PC_BITS > 0 ? 17 - PC_BITS : 0){1'b0}}, pc_reg}
                  < {{(PC_BITS > 17 ? PC_BITS - 17 : 0){1'b0}}, plen_reg});

    assign stat.need_mem = (op_reg == OP_POP) || (op_reg == OP_LOAD) || (op_reg == OP_RET);
    assign stat.need_div = live && (op_reg == OP_DIV || op_reg == OP_MOD) && (r3 != '0);
    assign stat.div_done = div_done;

    assign div_a = r2[31] ? -r2 : r2;
    assign div_b = r3[31] ? -r3 : r3;

    svm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    // commit: all writes and the result
    logic [31:0] rf_w [REG_COUNT];
    logic [PC_BITS-1:0] pc_w;
    logic halt_w;
    status_t st;
    logic [PC_BITS-1:0] tgt;
    logic jump;
    logic [31:0] sp_m1, sp_p1;
    logic [31:0] pc_x;

    assign sp_m1 = sp - 32'd1;
    assign sp_p1 = sp + 32'd1;

    always_comb
    begin
        rf_w   = rf_reg;
        halt_w = halt_reg;
        pc_w   = pc_reg;
        st     = ST_OK;
        we     = 1'b0;
        waddr  = sp_m1[AW-1:0];
        wdata  = a1_reg;
        jump   = 1'b0;
        tgt    = a1_reg[PC_BITS-1:0];
        if (halt_reg)
        begin
            st = ST_HALTED;
        end
        else if (!live)
        begin
            st = ST_PC_RANGE;
        end
        else
        begin
            case (op_reg)
                OP_PUSHI:
                begin
                    rf_w[SP] = sp_m1;
                    we = 1'b1;
                end
                OP_PUSHR:
                begin
                    if (!ok1_reg) st = ST_BAD_REG;
                    else
                    begin
                        rf_w[SP] = sp_m1;
                        we = 1'b1;
                        wdata = v1_reg;
                    end
                end
                OP_POP:
                begin
                    if (!ok1_reg) st = ST_BAD_REG;
                    else
                    begin
                        // popping into the stack register bumps the popped value
                        rf_w[a1_reg[RI-1:0]] = rdata;
                        rf_w[SP] = rf_w[SP] + 32'd1;
                    end
                end
                OP_ADD: rf_w[2] = r2 + r3;
                OP_SUB: rf_w[2] = r2 - r3;
                OP_MUL: rf_w[2] = mul_reg;
                OP_DIV:
                begin
                    if (r3 == '0) st = ST_DIV_ZERO;
                    else rf_w[2] = (r2[31] ^ r3[31]) ? -quo : quo;
                end
                OP_MOD:
                begin
                    if (r3 == '0) st = ST_DIV_ZERO;
                    else rf_w[2] = r2[31] ? -rem : rem;
                end
                OP_JE: jump = (r2 != '0);
                OP_JNE: jump = (r2 == '0);
                OP_JMP: jump = 1'b1;
                OP_LE: rf_w[2] = {31'd0, !($signed(r3) < $signed(r2))};
                OP_LT: rf_w[2] = {31'd0, $signed(r2) < $signed(r3)};
                OP_GE: rf_w[2] = {31'd0, !($signed(r2) < $signed(r3))};
                OP_GT: rf_w[2] = {31'd0, $signed(r3) < $signed(r2)};
                OP_EQ: rf_w[2] = {31'd0, r2 == r3};
                OP_NE: rf_w[2] = {31'd0, r2 != r3};
                OP_AND: rf_w[2] = {31'd0, (r2 != '0) && (r3 != '0)};
                OP_OR: rf_w[2] = {31'd0, (r2 != '0) || (r3 != '0)};
                OP_STORE:
                begin
                    if (!ok1_reg || !ok2_reg) st = ST_BAD_REG;
                    else
                    begin
                        we = 1'b1;
                        waddr = v1_reg[AW-1:0];
                        wdata = v2_reg;
                    end
                end
                OP_LOAD:
                begin
                    if (!ok1_reg || !ok2_reg) st = ST_BAD_REG;
                    else rf_w[a1_reg[RI-1:0]] = rdata;
                end
                OP_CALL:
                begin
                    rf_w[SP] = sp_m1;
                    we = 1'b1;
                    wdata = 32'(pc_reg);
                    jump = 1'b1;
                end
                OP_RET:
                begin
                    rf_w[SP] = sp_p1;
                    jump = 1'b1;
                    tgt = rdata[PC_BITS-1:0];
                end
                OP_MOVE:
                begin
                    if (!ok1_reg || !ok2_reg) st = ST_BAD_REG;
                    else rf_w[a1_reg[RI-1:0]] = v2_reg;
                end
                OP_MOVEI:
                begin
                    if (!ok1_reg) st = ST_BAD_REG;
                    else rf_w[a1_reg[RI-1:0]] = a2_reg;
                end
                OP_INT: st = ST_SERVICE;
                OP_EXIT: halt_w = 1'b1;
                default: ;
            endcase
            if (st == ST_OK)
            begin
                pc_w = (jump ? tgt : pc_reg) + 1'b1;
            end
            else
            begin
                we = 1'b0;
                rf_w = rf_reg;
            end
        end
        we = we && cmd.commit;
    end

    assign pc_x = 32'(pc_w);

    svm_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= (i == SP) ? 32'(MEM_DEPTH) : 32'd0;
            end
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            plen_reg <= 17'h10000;
        end
        else
        begin
            if (cfg_we)
            begin
                plen_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                rf_reg   <= rf_w;
                pc_reg   <= pc_w;
                halt_reg <= halt_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= {4'b0, st, halt_w, rf_w[2], pc_x[15:0]};
        end
    end

    assign out_data = res_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halt_reg) |-> halt_reg) else $error("halt flag cleared");
    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg && $past(halt_reg) |-> $stable(pc_reg)) else $error("pc moved when halted");
    a_no_write_fault: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> st == ST_OK) else $error("memory write on fault");
endmodule
